// ----- rtl/dap_pkg.sv -----
`default_nettype none

package dap_pkg;

   // one input item: a datagram byte and its end mark
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   // one result item
   typedef struct packed {
      logic        item_kind;
      logic [7:0]  name_byte;
      logic        accepted;
      logic [7:0]  capability_flags;
      logic [7:0]  system_code;
      logic [15:0] advert_port;
      logic [15:0] width_limit;
      logic [15:0] height_limit;
      logic [15:0] frame_rate_limit;
      logic [7:0]  name_length;
      logic        last_of_run;
   } rsp_type;

   localparam int unsigned POS_W = 10;
   localparam logic [POS_W-1:0] POS_LIMIT    = 10'd1023;
   localparam logic [POS_W-1:0] HEADER_BYTES = 10'd17;
   localparam logic [POS_W-1:0] MIN_TOTAL    = 10'd18;

   localparam logic [7:0] PROTO_VERSION = 8'd2;
   localparam logic [7:0] KIND_ADVERT   = 8'd2;

   localparam int unsigned FLAG_CONTROLLABLE = 0;
   localparam int unsigned FLAG_HEVC         = 2;
   localparam int unsigned FLAG_HDR10        = 3;
   localparam int unsigned FLAG_UNKNOWN      = 7;

   localparam logic KIND_NAME    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic CSR_SYSTEM_CODE_MIN = 1'b0;
   localparam logic CSR_SYSTEM_CODE_MAX = 1'b1;

   localparam logic [7:0] SYSTEM_CODE_MIN_RESET = 8'd1;
   localparam logic [7:0] SYSTEM_CODE_MAX_RESET = 8'd3;

   // expected magic "MSD1", one byte per header position
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h4D;
         2'd1:    b = 8'h53;
         2'd2:    b = 8'h44;
         default: b = 8'h31;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/discovery_advert_parser_top.sv -----
`default_nettype none

// Flow: an item is taken into the input register, parsed into the result queue once
//   the queue has room for two result items, and shown on rsp_ from the queue head.
// Throughput: 1 input item per cycle while the queue has room; a final name byte
//   yields 2 result items; a 4-entry queue drains them at 1 per cycle unless stalled.
// Reset: synchronous, active high; clears parser state and queue, system code bounds
//   return to 1 and 3.
module discovery_advert_parser_top
   import dap_pkg::*;
#(
   parameter int unsigned MAX_NAME_BYTES   = 64,
   parameter int unsigned MAX_PACKET_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_write_data
);

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

   // configuration registers
   logic [7:0] sys_min_ff, sys_max_ff;

   // input register
   logic    in_valid_ff;
   req_type in_data_ff;

   // parser state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             mismatch_ff, mismatch_in;
   logic [7:0]       flags_ff, flags_in;
   logic [7:0]       system_ff, system_in;
   logic [15:0]      port_ff, port_in;
   logic [15:0]      width_ff, width_in;
   logic [15:0]      height_ff, height_in;
   logic [15:0]      fps_ff, fps_in;
   logic [7:0]       nlen_ff, nlen_in;

   // result queue
   rsp_type          fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic    proc_go, in_take, pop;
   logic    name_hit, is_last, pass;
   logic [1:0] n_push;
   rsp_type name_item, verdict_item, slot0, slot1;
   logic [7:0] b;

   // queue must hold room for the worst case of two result items
   assign proc_go   = in_valid_ff && (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_stall = in_valid_ff && !proc_go;
   assign in_take   = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   assign b       = in_data_ff.data_byte;
   assign is_last = in_data_ff.end_of_packet;

   // field capture, one header position per byte
   always_comb begin
      mismatch_in = mismatch_ff;
      flags_in    = flags_ff;
      system_in   = system_ff;
      port_in     = port_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      fps_in      = fps_ff;
      nlen_in     = nlen_ff;
      if (pos_ff < 10'd4) begin
         if (b != magic_byte(pos_ff[1:0])) mismatch_in = 1'b1;
      end else if (pos_ff == 10'd4) begin
         if (b != PROTO_VERSION) mismatch_in = 1'b1;
      end else if (pos_ff == 10'd5) begin
         if (b != KIND_ADVERT) mismatch_in = 1'b1;
      end else if (pos_ff == 10'd6) begin
         flags_in = b;
      end else if (pos_ff == 10'd7) begin
         system_in = b;
      end else if (pos_ff <= 10'd9) begin
         port_in = {port_ff[7:0], b};
      end else if (pos_ff <= 10'd11) begin
         width_in = {width_ff[7:0], b};
      end else if (pos_ff <= 10'd13) begin
         height_in = {height_ff[7:0], b};
      end else if (pos_ff <= 10'd15) begin
         fps_in = {fps_ff[7:0], b};
      end else if (pos_ff == 10'd16) begin
         nlen_in = b;
      end
      // byte counter saturates
      pos_in = (pos_ff < POS_LIMIT) ? pos_ff + 10'd1 : pos_ff;
   end

   // bytes from position 17 on are name bytes
   assign name_hit = (pos_in > HEADER_BYTES);

   // verdict over the values that include this byte; pos_in is the total length
   always_comb begin
      pass = 1'b1;
      if (pos_in < MIN_TOTAL || pos_in > POS_W'(MAX_PACKET_BYTES)) pass = 1'b0;
      if (mismatch_in) pass = 1'b0;
      if (flags_in[FLAG_UNKNOWN] || !flags_in[FLAG_CONTROLLABLE]) pass = 1'b0;
      if (system_in < sys_min_ff || system_in > sys_max_ff) pass = 1'b0;
      if (port_in == '0 || width_in == '0 || height_in == '0 || fps_in == '0) pass = 1'b0;
      if (nlen_in == '0 || nlen_in > 8'(MAX_NAME_BYTES)) pass = 1'b0;
      if (pos_in != HEADER_BYTES + {2'b00, nlen_in}) pass = 1'b0;
      // HDR10 only alongside HEVC
      if (flags_in[FLAG_HDR10] && !flags_in[FLAG_HEVC]) pass = 1'b0;
   end

   always_comb begin
      name_item           = '0;
      name_item.item_kind = KIND_NAME;
      name_item.name_byte = b;
      name_item.last_of_run = !is_last;

      verdict_item                  = '0;
      verdict_item.item_kind        = KIND_VERDICT;
      verdict_item.accepted         = pass;
      verdict_item.capability_flags = flags_in;
      verdict_item.system_code      = system_in;
      verdict_item.advert_port      = port_in;
      verdict_item.width_limit      = width_in;
      verdict_item.height_limit     = height_in;
      verdict_item.frame_rate_limit = fps_in;
      verdict_item.name_length      = nlen_in;
      verdict_item.last_of_run      = 1'b1;

      slot0  = name_hit ? name_item : verdict_item;
      slot1  = verdict_item;
      n_push = proc_go ? ({1'b0, name_hit} + {1'b0, is_last}) : 2'd0;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_min_ff <= SYSTEM_CODE_MIN_RESET;
         sys_max_ff <= SYSTEM_CODE_MAX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SYSTEM_CODE_MIN: sys_min_ff <= csr_write_data;
            CSR_SYSTEM_CODE_MAX: sys_max_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
   end

   // parser state; a verdict returns everything to its reset value
   always_ff @(posedge clock) begin
      if (reset || (proc_go && is_last)) begin
         pos_ff      <= '0;
         mismatch_ff <= 1'b0;
         flags_ff    <= '0;
         system_ff   <= '0;
         port_ff     <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         fps_ff      <= '0;
         nlen_ff     <= '0;
      end else if (proc_go) begin
         pos_ff      <= pos_in;
         mismatch_ff <= mismatch_in;
         flags_ff    <= flags_in;
         system_ff   <= system_in;
         port_ff     <= port_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         fps_ff      <= fps_in;
         nlen_ff     <= nlen_in;
      end
   end

   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(n_push);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(n_push) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= slot0;
      end
      if (n_push == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= slot1;
      end
   end

`ifndef SYNTHESIS
   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a verdict restarts the byte count
   assert property (@(posedge clock) disable iff (reset)
      (proc_go && is_last) |=> (pos_ff == '0 && !mismatch_ff))
      else $error("parser state not cleared after verdict");

   // a verdict always closes its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.item_kind == KIND_VERDICT) |-> rsp_data.last_of_run)
      else $error("verdict without last_of_run");

   // input is held back only when the queue lacks room
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && count_ff > CNT_W'(FIFO_DEPTH - 2)))
      else $error("spurious input stall");
`endif

endmodule

`default_nettype wire

// ----- tb/discovery_advert_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the parser's results and
// compares them in order.
module discovery_advert_checker
   import dap_pkg::*;
#(
   parameter int unsigned MAX_NAME_BYTES   = 64,
   parameter int unsigned MAX_PACKET_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data,
   output int         outstanding,
   output int         fail_count
);

   localparam logic [31:0] MAGIC_WORD = "MSD1";

   logic [7:0]       sys_min = SYSTEM_CODE_MIN_RESET;
   logic [7:0]       sys_max = SYSTEM_CODE_MAX_RESET;
   logic [POS_W-1:0] position = '0;
   logic             bad_header = 1'b0;
   logic [7:0]       flags_q = '0;
   logic [7:0]       system_q = '0;
   logic [7:0]       name_len_q = '0;
   logic [15:0]      port_q = '0;
   logic [15:0]      width_q = '0;
   logic [15:0]      height_q = '0;
   logic [15:0]      fps_q = '0;
   rsp_type          expected_q[$];
   int               errors = 0;

   assign fail_count = errors;

   function automatic void clear_parse();
      position   = '0;
      bad_header = 1'b0;
      flags_q    = '0;
      system_q   = '0;
      name_len_q = '0;
      port_q     = '0;
      width_q    = '0;
      height_q   = '0;
      fps_q      = '0;
   endfunction

   function automatic logic advert_ok(input logic [POS_W-1:0] total);
      logic ok;
      ok = 1'b1;
      if (total < MIN_TOTAL || total > MAX_PACKET_BYTES) ok = 1'b0;
      if (bad_header) ok = 1'b0;
      if (flags_q[FLAG_UNKNOWN] || !flags_q[FLAG_CONTROLLABLE]) ok = 1'b0;
      if (system_q < sys_min || system_q > sys_max) ok = 1'b0;
      if (port_q == 0 || width_q == 0 || height_q == 0 || fps_q == 0) ok = 1'b0;
      if (name_len_q == 0 || name_len_q > MAX_NAME_BYTES) ok = 1'b0;
      if (total != HEADER_BYTES + name_len_q) ok = 1'b0;
      if (flags_q[FLAG_HDR10] && !flags_q[FLAG_HEVC]) ok = 1'b0;
      return ok;
   endfunction

   // one datagram byte in, zero to two expected results out
   function automatic void absorb_byte(input logic [7:0] b, input logic eop);
      rsp_type r;
      if (position < 4) begin
         if (b != MAGIC_WORD[8*(3 - position[1:0]) +: 8]) bad_header = 1'b1;
      end else if (position == 4) begin
         if (b != PROTO_VERSION) bad_header = 1'b1;
      end else if (position == 5) begin
         if (b != KIND_ADVERT) bad_header = 1'b1;
      end else if (position == 6) begin
         flags_q = b;
      end else if (position == 7) begin
         system_q = b;
      end else if (position <= 9) begin
         port_q = {port_q[7:0], b};
      end else if (position <= 11) begin
         width_q = {width_q[7:0], b};
      end else if (position <= 13) begin
         height_q = {height_q[7:0], b};
      end else if (position <= 15) begin
         fps_q = {fps_q[7:0], b};
      end else if (position == 16) begin
         name_len_q = b;
      end
      if (position < POS_LIMIT) position = position + 1'b1;

      if (position > HEADER_BYTES) begin
         r = '0;
         r.item_kind   = KIND_NAME;
         r.name_byte   = b;
         r.last_of_run = !eop;
         expected_q.insert(expected_q.size(), r);
      end
      if (eop) begin
         r = '0;
         r.item_kind        = KIND_VERDICT;
         r.accepted         = advert_ok(position);
         r.capability_flags = flags_q;
         r.system_code      = system_q;
         r.advert_port      = port_q;
         r.width_limit      = width_q;
         r.height_limit     = height_q;
         r.frame_rate_limit = fps_q;
         r.name_length      = name_len_q;
         r.last_of_run      = 1'b1;
         expected_q.insert(expected_q.size(), r);
         clear_parse();
      end
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sys_min = SYSTEM_CODE_MIN_RESET;
         sys_max = SYSTEM_CODE_MAX_RESET;
         clear_parse();
         expected_q.delete();
      end else begin
         // results first, so an item taken at this edge cannot cover a stray result
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result with nothing expected, kind %0d", rsp_data.item_kind);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("item_kind", want.item_kind, rsp_data.item_kind);
               check_field("name_byte", want.name_byte, rsp_data.name_byte);
               check_field("accepted", want.accepted, rsp_data.accepted);
               check_field("capability_flags", want.capability_flags,
                           rsp_data.capability_flags);
               check_field("system_code", want.system_code, rsp_data.system_code);
               check_field("advert_port", want.advert_port, rsp_data.advert_port);
               check_field("width_limit", want.width_limit, rsp_data.width_limit);
               check_field("height_limit", want.height_limit, rsp_data.height_limit);
               check_field("frame_rate_limit", want.frame_rate_limit,
                           rsp_data.frame_rate_limit);
               check_field("name_length", want.name_length, rsp_data.name_length);
               check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_SYSTEM_CODE_MIN) sys_min = csr_write_data;
            else sys_max = csr_write_data;
         end
         if (req_valid && !req_stall)
            absorb_byte(req_data.data_byte, req_data.end_of_packet);
      end
      outstanding <= expected_q.size();
   end

endmodule

// ----- tb/tb_discovery_advert_parser_top.sv -----
`timescale 1ns / 1ps

module tb_discovery_advert_parser_top;
   import dap_pkg::*;

   localparam int unsigned MAX_NAME_BYTES   = 64;
   localparam int unsigned MAX_PACKET_BYTES = 512;
   // random share; directed and long datagrams bring the total to about 1650
   localparam int RANDOM_ITEMS = 490;
   localparam int PHASES       = 7;
   // wait after the last predicted result is taken, for the pipe to empty
   localparam int DRAIN_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = CSR_SYSTEM_CODE_MIN;
   logic [7:0] csr_write_data = '0;

   int outstanding;
   int fail_count;
   int sent_items = 0;

   // datagram being built, one byte per entry
   logic [7:0] pkt[$];
   // stimulus' own note of the bounds, used to aim system codes into range
   logic [7:0] bound_lo = SYSTEM_CODE_MIN_RESET;
   logic [7:0] bound_hi = SYSTEM_CODE_MAX_RESET;
   // a whole packet goes without gaps when set
   logic       quiet_send = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   discovery_advert_parser_top #(
      .MAX_NAME_BYTES  (MAX_NAME_BYTES),
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   discovery_advert_checker #(
      .MAX_NAME_BYTES  (MAX_NAME_BYTES),
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .outstanding     (outstanding),
      .fail_count      (fail_count)
   );

   // ---------------------------------------------------------------------------
   // Result side: per item, may hold stall first, then take it.
   // Now and then flips into a calm stretch where every result is taken at once.
   // ---------------------------------------------------------------------------
   initial begin : result_taker
      int  hold;
      logic calm;
      calm = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0) calm = !calm;
         hold = calm ? 0 : $urandom_range(0, 14);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------------------
   // Sender helpers
   // ---------------------------------------------------------------------------

   // Valid stays up between back-to-back items; it only drops when a gap is drawn.
   task automatic put_byte(input logic [7:0] b, input logic eop);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, eop};
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic send_packet();
      quiet_send = ($urandom_range(0, 3) == 0);
      foreach (pkt[i]) put_byte(pkt[i], i == pkt.size() - 1);
   endtask

   // Drop valid and wait until every predicted result has been taken, then let
   // the pipe empty. outstanding is registered, hence the first wait.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both bounds written back to back, min then max; enable stays high across the two writes
   task automatic write_bounds(input logic [7:0] lo, input logic [7:0] hi);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYSTEM_CODE_MIN;
      csr_write_data   <= lo;
      @(posedge clock);
      csr_index        <= CSR_SYSTEM_CODE_MAX;
      csr_write_data   <= hi;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bound_lo = lo;
      bound_hi = hi;
   endtask

   // ---------------------------------------------------------------------------
   // Packet builders
   // ---------------------------------------------------------------------------

   // appends one byte to the datagram
   function automatic void add_byte(input logic [7:0] v);
      pkt.insert(pkt.size(), v);
   endfunction

   // declared: name length byte; body: name bytes actually sent
   function automatic void build_advert(input int declared, input int body,
                                        input logic [7:0] flags, input logic [7:0] sys,
                                        input logic [15:0] port, input logic [15:0] width,
                                        input logic [15:0] height, input logic [15:0] fps);
      pkt.delete();
      add_byte("M");
      add_byte("S");
      add_byte("D");
      add_byte("1");
      add_byte(PROTO_VERSION);
      add_byte(KIND_ADVERT);
      add_byte(flags);
      add_byte(sys);
      add_byte(port[15:8]);
      add_byte(port[7:0]);
      add_byte(width[15:8]);
      add_byte(width[7:0]);
      add_byte(height[15:8]);
      add_byte(height[7:0]);
      add_byte(fps[15:8]);
      add_byte(fps[7:0]);
      add_byte(8'(declared));
      repeat (body) add_byte(8'($urandom_range(0, 255)));
   endfunction

   // mostly nonzero, with the edges and an occasional zero
   function automatic logic [15:0] field16();
      logic [15:0] v;
      case ($urandom_range(0, 19))
         0:       v = 16'h0000;
         1:       v = 16'h0001;
         2:       v = 16'hFFFF;
         default: v = 16'($urandom_range(1, 65535));
      endcase
      return v;
   endfunction

   function automatic logic [7:0] pick_system();
      if (bound_lo <= bound_hi && $urandom_range(0, 4) != 0)
         return 8'($urandom_range(bound_hi, bound_lo));
      return 8'($urandom_range(0, 255));
   endfunction

   // well-formed datagram, random content; names kept short so verdicts are common
   function automatic void random_advert();
      int n;
      logic [7:0] flags;
      case ($urandom_range(0, 19))
         0:       n = MAX_NAME_BYTES;
         1:       n = MAX_NAME_BYTES + 1;
         2, 3:    n = $urandom_range(1, MAX_NAME_BYTES);
         default: n = $urandom_range(1, 6);
      endcase
      flags = 8'($urandom_range(0, 127)) | 8'h01;
      if ($urandom_range(0, 9) == 0) flags = 8'($urandom_range(0, 255));
      build_advert(n, n, flags, pick_system(), field16(), field16(), field16(), field16());
   endfunction

   // one defect in an otherwise good datagram
   function automatic void corrupt_packet();
      int idx;
      int len;
      case ($urandom_range(0, 4))
         0: begin
            idx = $urandom_range(0, pkt.size() - 1);
            pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
         end
         1: begin
            len = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > len) void'(pkt.pop_back());
         end
         2: begin
            // name runs past its declared length
            repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
         end
         3: begin
            pkt[16] = 8'($urandom_range(0, 255));
         end
         default: begin
            idx = 8 + 2 * $urandom_range(0, 3);
            pkt[idx]     = 8'h00;
            pkt[idx + 1] = 8'h00;
         end
      endcase
   endfunction

   function automatic void build_noise();
      int len;
      pkt.delete();
      len = $urandom_range(1, 40);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
      // half the time a correct magic, so the rest of the header gets random bytes
      if (len >= 4 && $urandom_range(0, 1) == 1) begin
         pkt[0] = "M";
         pkt[1] = "S";
         pkt[2] = "D";
         pkt[3] = "1";
      end
   endfunction

   function automatic void make_random_packet();
      int pick;
      int len;
      pick = $urandom_range(0, 99);
      random_advert();
      if (pick >= 90) begin
         build_noise();
      end else if (pick >= 80) begin
         // cut inside the header: verdict only, too short
         len = $urandom_range(1, 17);
         while (pkt.size() > len) void'(pkt.pop_back());
      end else if (pick >= 60) begin
         corrupt_packet();
      end
   endfunction

   task automatic random_phase(input int budget);
      int start;
      start = sent_items;
      while (sent_items - start < budget) begin
         make_random_packet();
         send_packet();
         // now and then the sender holds off until the result side has caught up
         if ($urandom_range(0, 19) == 0) settle();
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [7:0] lo_set[PHASES];
      logic [7:0] hi_set[PHASES];
      lo_set = '{SYSTEM_CODE_MIN_RESET, 8'd0, 8'd5, 8'd200, 8'd255, 8'd0, 8'd0};
      hi_set = '{SYSTEM_CODE_MAX_RESET, 8'd255, 8'd5, 8'd10, 8'd255, 8'd0, 8'd0};
      lo_set[PHASES-1] = 8'($urandom_range(0, 255));
      hi_set[PHASES-1] = 8'($urandom_range(0, 255));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, with the reset bounds (1..3)
      // smallest packet that passes, lowest system code in range
      build_advert(1, 1, 8'h01, 8'd1, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
      send_packet();
      // every known flag, top system code, all fields at maximum
      build_advert(2, 2, 8'h7F, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_packet();
      // HDR10 without HEVC
      build_advert(2, 2, 8'h09, 8'd2, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();
      // unknown flag bit set
      build_advert(2, 2, 8'h81, 8'd2, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();
      // system code below the lower bound
      build_advert(1, 1, 8'h01, 8'd0, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();
      // end mark on the last header byte: verdict only
      build_advert(0, 0, 8'h01, 8'd2, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();
      // extra name bytes past the declared length
      build_advert(1, 3, 8'h05, 8'd2, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();
      // one-byte datagram
      pkt.delete();
      add_byte(8'hFF);
      send_packet();

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) write_bounds(lo_set[p], hi_set[p]);
         random_phase(RANDOM_ITEMS / PHASES);
      end

      // long datagram: past the packet limit and past the counter limit
      write_bounds(8'd1, 8'd3);
      build_advert(255, 1030 - 17, 8'h01, 8'd2, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();
      // state must be clean again after the saturated run
      build_advert(1, 1, 8'h01, 8'd2, 16'h1234, 16'h0780, 16'h0438, 16'h003C);
      send_packet();

      settle();
      if (fail_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // well beyond the slowest legal run (about 1700 items at full idling)
   initial begin : watchdog
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dap_pkg.sv
rtl/discovery_advert_parser_top.sv
tb/discovery_advert_checker.sv
tb/tb_discovery_advert_parser_top.sv
